// ===== rtl/core/cte_pkg.sv =====
// ---------------------------------------------------------------------------
// cte_pkg: shared types and constants of the capability table engine
// Opcodes, status codes, the stored entry layout and the command and status
// groups between controller and datapath.
// ---------------------------------------------------------------------------
package cte_pkg;

  localparam int unsigned SLOTS_DEF       = 1024;
  localparam int unsigned CHILD_SLOTS_DEF = 4;
  localparam int unsigned DEPTH_DEF       = 16;

  localparam int unsigned RIGHT_GRANT_BIT    = 4;
  localparam int unsigned RIGHT_TRANSFER_BIT = 8;

  localparam int unsigned IN_DATA_W  = 392;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned COUNT_W    = 17;

  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_DERIVE   = 3'd1,
    OP_CHECK    = 3'd2,
    OP_TRANSFER = 3'd3,
    OP_REVOKE   = 3'd4
  } opcode_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_NOT_FOUND   = 4'd1,
    ST_RIGHTS      = 4'd2,
    ST_RANGE       = 4'd3,
    ST_NO_GRANT    = 4'd4,
    ST_FULL        = 4'd5,
    ST_NO_TRANSFER = 4'd6,
    ST_DOMAIN      = 4'd7,
    ST_DEPTH       = 4'd8
  } status_t;

  typedef struct packed {
    logic [31:0] level;
    logic [63:0] object;
    logic [7:0]  otype;
    logic [31:0] domain;
    logic [63:0] length;
    logic [63:0] offset;
    logic [63:0] rights;
  } entry_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_NEWID,
    CMD_MOD_START,
    CMD_MOD_STEP,
    CMD_PROBE_RD,
    CMD_PROBE_NEXT,
    CMD_SET_PAR,
    CMD_PUSH,
    CMD_OVER,
    CMD_ENT_RD,
    CMD_XFER_WR,
    CMD_ALLOC_WR,
    CMD_CZERO,
    CMD_LINK_RD,
    CMD_LINK_NEXT,
    CMD_LINK_WR,
    CMD_RCH_RD,
    CMD_KEY_CH,
    CMD_RFREE,
    CMD_EMIT
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t cmd;
    logic    set_st;
    status_t st;
  } ctl_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    key_zero;
    logic    mod_done;
    logic    id_hit;
    logic    id_empty;
    logic    probe_last;
    logic    rights_ok;
    logic    range_ok;
    logic    grant_ok;
    logic    xfer_ok;
    logic    dom_ok;
    logic    ch_zero;
    logic    cur_last;
    logic    top_full;
    logic    stack_full;
    logic    stack_one;
    logic    clr_last;
    logic    over;
    logic    out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/capability_table_engine_core.sv =====
// ---------------------------------------------------------------------------
// capability_table_engine_core: open-addressed capability table
// Create, derive, check, transfer and revoke on a linearly probed table.
// ---------------------------------------------------------------------------
// usage
//   in_*  : one request per handshake; in_tuser carries the opcode, in_tdata
//           the operands. out_* : one result per request, in order.
//   a request is taken only while the sequencer is idle; the result sits in
//   an output register, so the next request is taken while the previous
//   result waits for out_tready. a stalled receiver holds the result and,
//   once the next request is done, holds the sequencer in its final state.
//   each request is taken, its slot hashed (a shortcut when SLOTS is a power
//   of two, else a restoring mod of the identifier), slots probed one at a
//   time on the single identifier memory port and a found entry read and
//   checked; create then clears its CHILD_SLOTS child links, derive adds a
//   create and a walk of up to CHILD_SLOTS parent child links; revoke reads
//   each child link, frees each entry and hashes and probes each live child;
//   the result is then loaded into the output register. one request at a time.
//   after reset the identifier memory is swept to empty, one slot a cycle,
//   over all SLOTS slots (1024 by default) before the first request is taken.
// ---------------------------------------------------------------------------
module capability_table_engine_core #(
  parameter int unsigned SLOTS       = cte_pkg::SLOTS_DEF,
  parameter int unsigned CHILD_SLOTS = cte_pkg::CHILD_SLOTS_DEF,
  parameter int unsigned DEPTH       = cte_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // cap_id, rights, range_offset, range_length, domain, target domain,
  // obj_type, object_handle
  input  logic [cte_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [2:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status, new_id, revoked_count, zero fill
  output logic [cte_pkg::OUT_DATA_W-1:0] out_tdata
);

  cte_pkg::ctl_cmd_t cmd;
  cte_pkg::dp_stat_t stat;

  // sequencer
  cte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (cte_pkg::opcode_t'(in_tuser)),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // table and registers
  cte_datapath #(
    .SLOTS       (SLOTS),
    .CHILD_SLOTS (CHILD_SLOTS),
    .DEPTH       (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/core/cte_ctrl.sv =====
// ---------------------------------------------------------------------------
// cte_ctrl: sequencing state machine
// Walks each request through lookup, allocation, checks, child linking and
// the revoke walk, issuing one datapath command per cycle.
// ---------------------------------------------------------------------------
module cte_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  cte_pkg::opcode_t  in_op,
  output logic              in_tready,
  input  cte_pkg::dp_stat_t stat,
  output cte_pkg::ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_NEWID, S_MODS, S_MOD, S_PRD, S_PCHK, S_ERD, S_ECHK,
    S_AWR, S_CZERO, S_LRD, S_LCHK, S_RTOP, S_RCHK, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_ROOT, PH_ALLOC, PH_CHILD} phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  assign in_tready = (state_r == S_IDLE);

  // next state and command
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    cmd.cmd    = cte_pkg::CMD_NONE;
    cmd.set_st = 1'b0;
    cmd.st     = cte_pkg::ST_OK;
    unique case (state_r)
      S_CLR: begin
        cmd.cmd = cte_pkg::CMD_CLEAR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cmd   = cte_pkg::CMD_LOAD;
          phase_nxt = PH_ROOT;
          priority case (in_op)
            cte_pkg::OP_CREATE: state_nxt = S_NEWID;
            cte_pkg::OP_DERIVE, cte_pkg::OP_CHECK,
            cte_pkg::OP_TRANSFER, cte_pkg::OP_REVOKE: state_nxt = S_MODS;
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_NEWID: begin
        cmd.cmd   = cte_pkg::CMD_NEWID;
        phase_nxt = PH_ALLOC;
        state_nxt = S_MODS;
      end
      S_MODS: begin
        if (stat.key_zero) begin
          cmd.set_st = (phase_r != PH_CHILD);
          cmd.st     = (phase_r == PH_ALLOC) ? cte_pkg::ST_FULL : cte_pkg::ST_NOT_FOUND;
          state_nxt  = (phase_r == PH_CHILD) ? S_RTOP : S_DONE;
        end else begin
          cmd.cmd   = cte_pkg::CMD_MOD_START;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (stat.mod_done) state_nxt = S_PRD;
        else cmd.cmd = cte_pkg::CMD_MOD_STEP;
      end
      S_PRD: begin
        cmd.cmd   = cte_pkg::CMD_PROBE_RD;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (phase_r == PH_ALLOC) begin
          if (stat.id_empty) begin
            state_nxt = S_AWR;
          end else if (stat.probe_last) begin
            cmd.set_st = 1'b1;
            cmd.st     = cte_pkg::ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            cmd.cmd   = cte_pkg::CMD_PROBE_NEXT;
            state_nxt = S_PRD;
          end
        end else if (stat.id_hit) begin
          if (phase_r == PH_CHILD) begin
            cmd.cmd   = stat.stack_full ? cte_pkg::CMD_OVER : cte_pkg::CMD_PUSH;
            state_nxt = S_RTOP;
          end else if (stat.op == cte_pkg::OP_REVOKE) begin
            cmd.cmd   = cte_pkg::CMD_PUSH;
            state_nxt = S_RTOP;
          end else begin
            cmd.cmd   = cte_pkg::CMD_SET_PAR;
            state_nxt = S_ERD;
          end
        end else if (stat.id_empty || stat.probe_last) begin
          if (phase_r == PH_CHILD) begin
            state_nxt = S_RTOP;
          end else begin
            cmd.set_st = 1'b1;
            cmd.st     = cte_pkg::ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end
        end else begin
          cmd.cmd   = cte_pkg::CMD_PROBE_NEXT;
          state_nxt = S_PRD;
        end
      end
      S_ERD: begin
        cmd.cmd   = cte_pkg::CMD_ENT_RD;
        state_nxt = S_ECHK;
      end
      S_ECHK: begin
        state_nxt = S_DONE;
        priority case (stat.op)
          cte_pkg::OP_DERIVE: begin
            cmd.set_st = 1'b1;
            priority if (!stat.rights_ok) cmd.st = cte_pkg::ST_RIGHTS;
            else if (!stat.range_ok)      cmd.st = cte_pkg::ST_RANGE;
            else if (!stat.grant_ok)      cmd.st = cte_pkg::ST_NO_GRANT;
            else begin
              cmd.set_st = 1'b0;
              state_nxt  = S_NEWID;
            end
          end
          cte_pkg::OP_CHECK: begin
            cmd.set_st = !stat.rights_ok;
            cmd.st     = cte_pkg::ST_RIGHTS;
          end
          cte_pkg::OP_TRANSFER: begin
            cmd.set_st = 1'b1;
            priority if (!stat.xfer_ok) cmd.st = cte_pkg::ST_NO_TRANSFER;
            else if (!stat.dom_ok)      cmd.st = cte_pkg::ST_DOMAIN;
            else begin
              cmd.set_st = 1'b0;
              cmd.cmd    = cte_pkg::CMD_XFER_WR;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_AWR: begin
        cmd.cmd   = cte_pkg::CMD_ALLOC_WR;
        state_nxt = S_CZERO;
      end
      S_CZERO: begin
        cmd.cmd = cte_pkg::CMD_CZERO;
        if (stat.cur_last)
          state_nxt = (stat.op == cte_pkg::OP_DERIVE) ? S_LRD : S_DONE;
      end
      S_LRD: begin
        cmd.cmd   = cte_pkg::CMD_LINK_RD;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        if (stat.ch_zero) begin
          cmd.cmd   = cte_pkg::CMD_LINK_WR;
          state_nxt = S_DONE;
        end else if (stat.cur_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.cmd   = cte_pkg::CMD_LINK_NEXT;
          state_nxt = S_LRD;
        end
      end
      S_RTOP: begin
        if (!stat.top_full) begin
          cmd.cmd   = cte_pkg::CMD_RCH_RD;
          state_nxt = S_RCHK;
        end else begin
          cmd.cmd = cte_pkg::CMD_RFREE;
          if (stat.stack_one) begin
            cmd.set_st = 1'b1;
            cmd.st     = stat.over ? cte_pkg::ST_DEPTH : cte_pkg::ST_OK;
            state_nxt  = S_DONE;
          end
        end
      end
      S_RCHK: begin
        if (stat.ch_zero) begin
          state_nxt = S_RTOP;
        end else begin
          cmd.cmd   = cte_pkg::CMD_KEY_CH;
          phase_nxt = PH_CHILD;
          state_nxt = S_MODS;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.cmd   = cte_pkg::CMD_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      phase_r <= PH_ROOT;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== rtl/core/cte_datapath.sv =====
// ---------------------------------------------------------------------------
// cte_datapath: table memories, probe unit and revoke stack
// Holds the identifier, entry and child-link memories, the slot hash unit,
// the request registers and the output register.
// ---------------------------------------------------------------------------
module cte_datapath #(
  parameter int unsigned SLOTS       = cte_pkg::SLOTS_DEF,
  parameter int unsigned CHILD_SLOTS = cte_pkg::CHILD_SLOTS_DEF,
  parameter int unsigned DEPTH       = cte_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [cte_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [2:0]                     in_tuser,
  input  cte_pkg::ctl_cmd_t              cmd,
  output cte_pkg::dp_stat_t              stat,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cte_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned SW   = $clog2(SLOTS);
  localparam int unsigned CURW = $clog2(CHILD_SLOTS + 1);
  localparam int unsigned CAW  = $clog2(SLOTS * CHILD_SLOTS);
  localparam int unsigned SPW  = $clog2(DEPTH + 1);
  localparam int unsigned TW   = $clog2(DEPTH);
  localparam bit          POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam int unsigned CW   = cte_pkg::COUNT_W;

  // memories
  logic [63:0]     id_mem  [SLOTS];
  cte_pkg::entry_t ent_mem [SLOTS];
  logic [63:0]     ch_mem  [SLOTS * CHILD_SLOTS];

  // request registers
  cte_pkg::opcode_t op_r;
  logic [63:0] rights_r, off_r, len_r, obj_r;
  logic [31:0] dom_r, to_dom_r;
  logic [7:0]  type_r;

  logic [63:0]     next_id_r, key_r, newid_r, id_q, ch_q, modsh_r;
  logic [SW-1:0]   rem_r, probe_r, probe_n_r, par_r, clr_r;
  logic [3:0]      mod_cnt_r;
  logic            mod_done_r, over_r;
  logic [CURW-1:0] cur_r;
  cte_pkg::entry_t ent_q;
  cte_pkg::status_t status_r;
  logic [CW-1:0]   count_r;

  // revoke stack
  logic [SW-1:0]   stk_slot [DEPTH];
  logic [CURW-1:0] stk_cur  [DEPTH];
  logic [SPW-1:0]  sp_r;
  logic [TW-1:0]   top;

  // output register
  logic             out_valid_r;
  cte_pkg::status_t out_st_r;
  logic [63:0]      out_id_r;
  logic [CW-1:0]    out_cnt_r;

  logic [SW-1:0]   rem_step;
  logic [SW:0]     rem_t;
  logic [CAW-1:0]  zero_addr, link_addr, walk_addr;
  cte_pkg::entry_t new_ent, xfer_ent;
  logic [63:0]     ent_end, req_end;

  assign top = TW'(sp_r - SPW'(1));

  // slot hash: four restoring steps of id mod SLOTS per cycle
  always_comb begin
    rem_step = rem_r;
    rem_t    = '0;
    for (int i = 0; i < 4; i++) begin
      rem_t = {rem_step, modsh_r[63-i]};
      if (rem_t >= (SW+1)'(SLOTS)) rem_t = rem_t - (SW+1)'(SLOTS);
      rem_step = rem_t[SW-1:0];
    end
  end

  // child-link addresses
  always_comb begin
    zero_addr = CAW'(probe_r) * CAW'(CHILD_SLOTS) + CAW'(cur_r);
    link_addr = CAW'(par_r) * CAW'(CHILD_SLOTS) + CAW'(cur_r);
    walk_addr = CAW'(stk_slot[top]) * CAW'(CHILD_SLOTS) + CAW'(stk_cur[top]);
  end

  // new and transferred entry words
  always_comb begin
    new_ent        = '0;
    new_ent.rights = rights_r;
    new_ent.offset = off_r;
    new_ent.length = len_r;
    if (op_r == cte_pkg::OP_DERIVE) begin
      new_ent.domain = ent_q.domain;
      new_ent.otype  = ent_q.otype;
      new_ent.object = ent_q.object;
      new_ent.level  = ent_q.level + 32'd1;
    end else begin
      new_ent.domain = dom_r;
      new_ent.otype  = type_r;
      new_ent.object = obj_r;
      new_ent.level  = 32'd0;
    end
    xfer_ent        = ent_q;
    xfer_ent.domain = to_dom_r;
    ent_end         = ent_q.offset + ent_q.length;
    req_end         = off_r + len_r;
  end

  // status towards the controller
  always_comb begin
    stat.op         = op_r;
    stat.key_zero   = (key_r == 64'd0);
    stat.mod_done   = mod_done_r;
    stat.id_hit     = (id_q == key_r);
    stat.id_empty   = (id_q == 64'd0);
    stat.probe_last = (probe_n_r == SW'(SLOTS - 1));
    stat.rights_ok  = ((ent_q.rights & rights_r) == rights_r);
    stat.range_ok   = (off_r >= ent_q.offset) && (req_end <= ent_end);
    stat.grant_ok   = ent_q.rights[cte_pkg::RIGHT_GRANT_BIT];
    stat.xfer_ok    = ent_q.rights[cte_pkg::RIGHT_TRANSFER_BIT];
    stat.dom_ok     = (ent_q.domain == dom_r);
    stat.ch_zero    = (ch_q == 64'd0);
    stat.cur_last   = (cur_r == CURW'(CHILD_SLOTS - 1));
    stat.top_full   = (stk_cur[top] == CURW'(CHILD_SLOTS));
    stat.stack_full = (sp_r == SPW'(DEPTH));
    stat.stack_one  = (sp_r == SPW'(1));
    stat.clr_last   = (clr_r == SW'(SLOTS - 1));
    stat.over       = over_r;
    stat.out_free   = !out_valid_r || out_tready;
  end

  // identifier memory
  always_ff @(posedge clk) begin
    if (cmd.cmd == cte_pkg::CMD_CLEAR) id_mem[clr_r] <= 64'd0;
    else if (cmd.cmd == cte_pkg::CMD_ALLOC_WR) id_mem[probe_r] <= key_r;
    else if (cmd.cmd == cte_pkg::CMD_RFREE) id_mem[stk_slot[top]] <= 64'd0;
    if (cmd.cmd == cte_pkg::CMD_PROBE_RD) id_q <= id_mem[probe_r];
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (cmd.cmd == cte_pkg::CMD_ALLOC_WR) ent_mem[probe_r] <= new_ent;
    else if (cmd.cmd == cte_pkg::CMD_XFER_WR) ent_mem[par_r] <= xfer_ent;
    if (cmd.cmd == cte_pkg::CMD_ENT_RD) ent_q <= ent_mem[par_r];
  end

  // child-link memory
  always_ff @(posedge clk) begin
    if (cmd.cmd == cte_pkg::CMD_CZERO) ch_mem[zero_addr] <= 64'd0;
    else if (cmd.cmd == cte_pkg::CMD_LINK_WR) ch_mem[link_addr] <= newid_r;
    if (cmd.cmd == cte_pkg::CMD_LINK_RD) ch_q <= ch_mem[link_addr];
    else if (cmd.cmd == cte_pkg::CMD_RCH_RD) ch_q <= ch_mem[walk_addr];
  end

  // request, hash, probe and stack registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r <= 64'd1;
      clr_r     <= '0;
      sp_r      <= '0;
    end else begin
      unique case (cmd.cmd)
        cte_pkg::CMD_CLEAR: clr_r <= clr_r + SW'(1);
        cte_pkg::CMD_LOAD: begin
          op_r     <= cte_pkg::opcode_t'(in_tuser);
          key_r    <= in_tdata[63:0];
          rights_r <= in_tdata[127:64];
          off_r    <= in_tdata[191:128];
          len_r    <= in_tdata[255:192];
          dom_r    <= in_tdata[287:256];
          to_dom_r <= in_tdata[319:288];
          type_r   <= in_tdata[327:320];
          obj_r    <= in_tdata[391:328];
          newid_r  <= 64'd0;
          count_r  <= '0;
          over_r   <= 1'b0;
          sp_r     <= '0;
          cur_r    <= '0;
        end
        cte_pkg::CMD_NEWID: begin
          key_r     <= next_id_r;
          next_id_r <= next_id_r + 64'd1;
        end
        cte_pkg::CMD_MOD_START: begin
          modsh_r    <= key_r;
          rem_r      <= '0;
          mod_cnt_r  <= '0;
          mod_done_r <= POW2;
          probe_r    <= key_r[SW-1:0];
          probe_n_r  <= '0;
        end
        cte_pkg::CMD_MOD_STEP: begin
          modsh_r   <= {modsh_r[59:0], 4'd0};
          rem_r     <= rem_step;
          mod_cnt_r <= mod_cnt_r + 4'd1;
          if (mod_cnt_r == 4'hF) begin
            mod_done_r <= 1'b1;
            probe_r    <= rem_step;
          end
        end
        cte_pkg::CMD_PROBE_NEXT: begin
          probe_r   <= (probe_r == SW'(SLOTS - 1)) ? '0 : probe_r + SW'(1);
          probe_n_r <= probe_n_r + SW'(1);
        end
        cte_pkg::CMD_SET_PAR: par_r <= probe_r;
        cte_pkg::CMD_PUSH: begin
          stk_slot[TW'(sp_r)] <= probe_r;
          stk_cur[TW'(sp_r)]  <= '0;
          sp_r                <= sp_r + SPW'(1);
        end
        cte_pkg::CMD_OVER: over_r <= 1'b1;
        cte_pkg::CMD_ALLOC_WR: begin
          newid_r <= key_r;
          cur_r   <= '0;
        end
        cte_pkg::CMD_CZERO:
          cur_r <= (cur_r == CURW'(CHILD_SLOTS - 1)) ? '0 : cur_r + CURW'(1);
        cte_pkg::CMD_LINK_NEXT: cur_r <= cur_r + CURW'(1);
        cte_pkg::CMD_RCH_RD: stk_cur[top] <= stk_cur[top] + CURW'(1);
        cte_pkg::CMD_KEY_CH: key_r <= ch_q;
        cte_pkg::CMD_RFREE: begin
          if (count_r != {CW{1'b1}}) count_r <= count_r + CW'(1);
          sp_r <= sp_r - SPW'(1);
        end
        default: ;
      endcase
    end
  end

  // result status and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cmd == cte_pkg::CMD_LOAD) status_r <= cte_pkg::ST_OK;
      else if (cmd.set_st) status_r <= cmd.st;
      if (cmd.cmd == cte_pkg::CMD_EMIT) begin
        out_valid_r <= 1'b1;
        out_st_r    <= status_r;
        out_id_r    <= (status_r == cte_pkg::ST_OK) ? newid_r : 64'd0;
        out_cnt_r   <= count_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_cnt_r, out_id_r, out_st_r};

  // the walk never pushes beyond the stack
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(DEPTH)) else $error("revoke stack pointer beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cmd == cte_pkg::CMD_PUSH) |-> (sp_r < SPW'(DEPTH)))
    else $error("push on a full revoke stack");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cmd == cte_pkg::CMD_EMIT) |-> (!out_valid_r || out_tready))
    else $error("result written over an untaken result");

  a_count_revoke: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cmd == cte_pkg::CMD_EMIT && count_r != '0) |-> (op_r == cte_pkg::OP_REVOKE))
    else $error("revoke count on a non-revoke request");

endmodule

// ===== tb/sv/capability_table_engine_core_chk.sv =====
// ---------------------------------------------------------------------------
// capability_table_engine_core_chk: result checker of the capability table
// Watches both streams, predicts each result from a private copy of the
// table and compares every result, field by field, in request order.
// ---------------------------------------------------------------------------
module capability_table_engine_core_chk (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [cte_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [2:0]                     in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [cte_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = cte_pkg::SLOTS_DEF;
  localparam int NCH   = cte_pkg::CHILD_SLOTS_DEF;
  localparam int NDEP  = cte_pkg::DEPTH_DEF;
  localparam logic [63:0] GRANT_MASK = 64'd1 << cte_pkg::RIGHT_GRANT_BIT;
  localparam logic [63:0] XFER_MASK  = 64'd1 << cte_pkg::RIGHT_TRANSFER_BIT;

  typedef struct {
    cte_pkg::status_t st;
    logic [63:0]      id;
    logic [16:0]      cnt;
  } cap_result_t;

  // shadow of the table
  logic [63:0] id_counter;
  logic [63:0] tab_id     [NSLOT];
  logic [63:0] tab_rights [NSLOT];
  logic [63:0] tab_off    [NSLOT];
  logic [63:0] tab_len    [NSLOT];
  logic [31:0] tab_dom    [NSLOT];
  logic [7:0]  tab_type   [NSLOT];
  logic [63:0] tab_obj    [NSLOT];
  logic [31:0] tab_level  [NSLOT];
  logic [63:0] tab_child  [NSLOT*NCH];
  int          walk_slot  [NDEP];
  int          walk_cur   [NDEP];

  cap_result_t result_q[$];

  assign pending = result_q.size();

  // linear probe; stops on an empty slot
  function automatic bit lookup_slot(input logic [63:0] id, output int where);
    int s;
    where = 0;
    if (id == 0) return 0;
    s = int'(id % NSLOT);
    for (int n = 0; n < NSLOT; n++) begin
      if (tab_id[s] == id) begin
        where = s;
        return 1;
      end
      if (tab_id[s] == 0) return 0;
      s = (s + 1) % NSLOT;
    end
    return 0;
  endfunction

  function automatic bit alloc_slot(input logic [7:0] ty, input logic [63:0] obj,
                                    input logic [63:0] off, input logic [63:0] len,
                                    input logic [63:0] rights, input logic [31:0] dom,
                                    output int where, output logic [63:0] id);
    int s;
    id = id_counter;
    where = 0;
    id_counter = id_counter + 64'd1;
    if (id == 0) return 0;
    s = int'(id % NSLOT);
    for (int n = 0; n < NSLOT; n++) begin
      if (tab_id[s] == 0) begin
        tab_id[s] = id;
        tab_type[s] = ty;
        tab_obj[s] = obj;
        tab_off[s] = off;
        tab_len[s] = len;
        tab_rights[s] = rights;
        tab_dom[s] = dom;
        tab_level[s] = 0;
        for (int c = 0; c < NCH; c++) tab_child[s*NCH+c] = 0;
        where = s;
        return 1;
      end
      s = (s + 1) % NSLOT;
    end
    id = 0;
    return 0;
  endfunction

  function automatic cap_result_t predict_request(input logic [2:0] op,
                                                  input logic [cte_pkg::IN_DATA_W-1:0] d);
    cap_result_t r;
    logic [63:0] id, rights, off, len, nid, ch;
    logic [31:0] dom, to_dom;
    int s, cs, sp, t;
    bit over;
    id = d[63:0];
    rights = d[127:64];
    off = d[191:128];
    len = d[255:192];
    dom = d[287:256];
    to_dom = d[319:288];
    r.st = cte_pkg::ST_OK;
    r.id = 0;
    r.cnt = 0;
    case (op)
      cte_pkg::OP_CREATE: begin
        if (alloc_slot(d[327:320], d[391:328], off, len, rights, dom, cs, nid))
          r.id = nid;
        else
          r.st = cte_pkg::ST_FULL;
      end
      cte_pkg::OP_DERIVE: begin
        if (!lookup_slot(id, s)) r.st = cte_pkg::ST_NOT_FOUND;
        else if ((tab_rights[s] & rights) != rights) r.st = cte_pkg::ST_RIGHTS;
        else if (off < tab_off[s] || off + len > tab_off[s] + tab_len[s])
          r.st = cte_pkg::ST_RANGE;
        else if ((tab_rights[s] & GRANT_MASK) == 0) r.st = cte_pkg::ST_NO_GRANT;
        else if (!alloc_slot(tab_type[s], tab_obj[s], off, len, rights, tab_dom[s],
                             cs, nid)) r.st = cte_pkg::ST_FULL;
        else begin
          r.id = nid;
          tab_level[cs] = tab_level[s] + 1;
          // link into the first free child slot, if any
          for (int c = 0; c < NCH; c++) begin
            if (tab_child[s*NCH+c] == 0) begin
              tab_child[s*NCH+c] = nid;
              break;
            end
          end
        end
      end
      cte_pkg::OP_CHECK: begin
        if (!lookup_slot(id, s)) r.st = cte_pkg::ST_NOT_FOUND;
        else if ((tab_rights[s] & rights) != rights) r.st = cte_pkg::ST_RIGHTS;
      end
      cte_pkg::OP_TRANSFER: begin
        if (!lookup_slot(id, s)) r.st = cte_pkg::ST_NOT_FOUND;
        else if ((tab_rights[s] & XFER_MASK) == 0) r.st = cte_pkg::ST_NO_TRANSFER;
        else if (tab_dom[s] != dom) r.st = cte_pkg::ST_DOMAIN;
        else tab_dom[s] = to_dom;
      end
      cte_pkg::OP_REVOKE: begin
        if (!lookup_slot(id, s)) r.st = cte_pkg::ST_NOT_FOUND;
        else begin
          // post-order walk, children before parent
          sp = 1;
          over = 0;
          walk_slot[0] = s;
          walk_cur[0] = 0;
          while (sp > 0) begin
            t = sp - 1;
            if (walk_cur[t] < NCH) begin
              ch = tab_child[walk_slot[t]*NCH + walk_cur[t]];
              walk_cur[t]++;
              if (ch != 0 && lookup_slot(ch, cs)) begin
                if (sp < NDEP) begin
                  walk_slot[sp] = cs;
                  walk_cur[sp] = 0;
                  sp++;
                end else over = 1;
              end
            end else begin
              tab_rights[walk_slot[t]] = 0;
              tab_type[walk_slot[t]] = 0;
              tab_obj[walk_slot[t]] = 0;
              tab_id[walk_slot[t]] = 0;
              if (r.cnt != 17'h1FFFF) r.cnt++;
              sp--;
            end
          end
          if (over) r.st = cte_pkg::ST_DEPTH;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    cap_result_t exp_r;
    if (!rst_n) begin
      id_counter = 1;
      for (int i = 0; i < NSLOT; i++) tab_id[i] = 0;
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (out_tdata[3:0] != exp_r.st || out_tdata[67:4] != exp_r.id ||
              out_tdata[84:68] != exp_r.cnt) begin
            $display("%0t: result mismatch, expected status %0d id %0h count %0d,",
                     $time, exp_r.st, exp_r.id, exp_r.cnt,
                     " actual status %0d id %0h count %0d",
                     out_tdata[3:0], out_tdata[67:4], out_tdata[84:68]);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        result_q.push_back(predict_request(in_tuser, in_tdata));
    end
  end

endmodule

// ===== tb/sv/capability_table_engine_core_tb.sv =====
// ---------------------------------------------------------------------------
// capability_table_engine_core_tb: stimulus for the capability table engine
// Directed requests (deep derive chain, extremes, unused opcodes) followed
// by random request mixes with random stalls on both streams.
// ---------------------------------------------------------------------------
module capability_table_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam logic [63:0] ALL_ONES = '1;

  logic                           clk = 0;
  logic                           rst_n = 0;
  logic                           in_tvalid = 0;
  logic                           in_tready;
  logic [cte_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [2:0]                     in_tuser = '0;
  logic                           out_tvalid;
  logic                           out_tready = 0;
  logic [cte_pkg::OUT_DATA_W-1:0] out_tdata;
  int                             fail_count;
  int                             pending;
  int                             cycles = 0;
  bit                             stalls_on = 1;
  logic [63:0]                    ids_issued = 0;

  capability_table_engine_core dut (.*);
  capability_table_engine_core_chk chk (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk)
    out_tready <= !stalls_on || ($urandom_range(0, 99) >= 38);

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // drive at a falling edge, hold until taken, release at the next falling edge
  task automatic send_request(input logic [2:0] op, input logic [63:0] id,
                              input logic [63:0] rights, input logic [63:0] off,
                              input logic [63:0] len, input logic [31:0] dom,
                              input logic [31:0] to_dom, input logic [7:0] ty,
                              input logic [63:0] obj);
    @(negedge clk);
    while (stalls_on && $urandom_range(0, 99) < 38) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {obj, ty, to_dom, dom, len, off, rights, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    in_tvalid <= 1'b0;
    if (op == cte_pkg::OP_CREATE || op == cte_pkg::OP_DERIVE) ids_issued++;
  endtask

  // pick a mostly live identifier
  function automatic logic [63:0] pick_id();
    int k;
    k = $urandom_range(0, 99);
    if (k < 4) return 64'd0;
    if (k < 8) return rnd64();
    return 64'($urandom_range(1, (ids_issued > 0) ? int'(ids_issued) + 1 : 1));
  endfunction

  task automatic random_request();
    int k;
    logic [63:0] r;
    k = $urandom_range(0, 99);
    if (k < 25) begin
      r = ($urandom_range(0, 9) < 7) ? (rnd64() | 64'h110) : rnd64();
      if ($urandom_range(0, 9) < 8)
        send_request(cte_pkg::OP_CREATE, rnd64(), r, 64'($urandom_range(0, 1000)),
                     64'($urandom_range(4096, 1 << 20)), 32'($urandom_range(0, 3)),
                     $urandom, 8'($urandom), rnd64());
      else
        send_request(cte_pkg::OP_CREATE, rnd64(), r, rnd64(), rnd64(), $urandom,
                     $urandom, 8'($urandom), rnd64());
    end else if (k < 55) begin
      r = ($urandom_range(0, 9) < 8) ? {32'd0, $urandom & 32'h1FF} : rnd64();
      send_request(cte_pkg::OP_DERIVE, pick_id(), r, 64'($urandom_range(0, 2000)),
                   64'($urandom_range(0, 4096)), $urandom, $urandom, 8'($urandom),
                   rnd64());
    end else if (k < 70) begin
      r = ($urandom_range(0, 1) == 0) ? {32'd0, $urandom & 32'h1FF} : rnd64();
      send_request(cte_pkg::OP_CHECK, pick_id(), r, rnd64(), rnd64(), $urandom,
                   $urandom, 8'($urandom), rnd64());
    end else if (k < 82) begin
      send_request(cte_pkg::OP_TRANSFER, pick_id(), rnd64(), rnd64(), rnd64(),
                   32'($urandom_range(0, 3)), 32'($urandom_range(0, 3)), 8'($urandom),
                   rnd64());
    end else if (k < 92) begin
      send_request(cte_pkg::OP_REVOKE, pick_id(), rnd64(), rnd64(), rnd64(), $urandom,
                   $urandom, 8'($urandom), rnd64());
    end else begin
      send_request(3'($urandom_range(5, 7)), rnd64(), rnd64(), rnd64(), rnd64(),
                   $urandom, $urandom, 8'($urandom), rnd64());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: widest create, then a derive chain deeper than the revoke stack
    send_request(cte_pkg::OP_CREATE, ALL_ONES, ALL_ONES, 64'd0, ALL_ONES, '1, '1,
                 8'hFF, ALL_ONES);
    for (int i = 1; i <= 17; i++)
      send_request(cte_pkg::OP_DERIVE, 64'(i), ALL_ONES, 64'd0, ALL_ONES, '0, '0,
                   '0, '0);
    // range wrapping past the parent end, missing grant, zero id, transfers, revokes, opcode 7
    send_request(cte_pkg::OP_CREATE, '0, 64'h100, 64'd10, 64'd20, 32'd5, '0, 8'h01,
                 64'd7);
    send_request(cte_pkg::OP_DERIVE, 64'd19, 64'h100, 64'd10, ALL_ONES, '0, '0, '0, '0);
    send_request(cte_pkg::OP_DERIVE, 64'd19, 64'h100, 64'd12, 64'd4, '0, '0, '0, '0);
    send_request(cte_pkg::OP_CHECK, '0, '0, '0, '0, '0, '0, '0, '0);
    send_request(cte_pkg::OP_TRANSFER, 64'd19, '0, '0, '0, 32'd4, 32'd9, '0, '0);
    send_request(cte_pkg::OP_TRANSFER, 64'd19, '0, '0, '0, 32'd5, '1, '0, '0);
    send_request(cte_pkg::OP_REVOKE, 64'd1, '0, '0, '0, '0, '0, '0, '0);
    send_request(cte_pkg::OP_REVOKE, 64'd1, '0, '0, '0, '0, '0, '0, '0);
    send_request(3'd7, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, '1, '1, '1, ALL_ONES);

    // random part, with a stretch free of stalls and a full drain midway
    for (int n = 0; n < 450; n++) begin
      stalls_on = !(n >= 150 && n < 230);
      if (n == 300) wait (pending == 0);
      random_request();
    end

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
